@@ design/ffca_pkg.sv @@
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared constants, types and state encoding of the first-fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffca_pkg;

    localparam int HEAP_BYTES   = 4096;
    localparam int HEADER_BYTES = 8;
    localparam int ALIGN_STEP   = 4;
    localparam int MIN_SPLIT    = HEADER_BYTES + ALIGN_STEP;
    localparam int DEPTH        = HEAP_BYTES / ALIGN_STEP;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int OFF_W        = 12;
    localparam int REQ_W        = 16;
    localparam int NEED_W       = REQ_W + 1;
    localparam int CNT_W        = IDX_W + 1;

    localparam logic [OFF_W-1:0] TAIL_OFF  = OFF_W'((HEAP_BYTES - HEADER_BYTES) & ~3);
    localparam logic [OFF_W-1:0] PEAK_INIT = OFF_W'(HEAP_BYTES - ((HEAP_BYTES - HEADER_BYTES) & ~3));
    localparam logic [CNT_W-1:0] WALK_MAX  = CNT_W'(DEPTH + 1);

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHK,
        S_A_TAKE,
        S_A_SPLIT,
        S_A_RD,
        S_A_FIN,
        S_R_SIZE,
        S_RI_WALK,
        S_RI_IT,
        S_RI_ITD,
        S_RI_BLK,
        S_RI_NEXT,
        S_RI_NXD,
        S_RI_LINK,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ design/ffca_if.sv @@
// ----------------------------------------------------------------------------
// ffca request / response channels
// Valid-ready channels carrying one allocator command and one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffca_req_if
    import ffca_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              operation;
    logic [REQ_W-1:0]  request_bytes;
    logic [OFF_W-1:0]  release_offset;

    modport source (output valid, operation, request_bytes, release_offset, input ready);
    modport sink   (input valid, operation, request_bytes, release_offset, output ready);
endinterface

interface ffca_rsp_if
    import ffca_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OFF_W-1:0]  granted_offset;
    logic              success;
    logic [OFF_W-1:0]  free_total;
    logic [OFF_W-1:0]  peak_usage;
    logic [OFF_W-1:0]  pool_bytes;

    modport source (output valid, granted_offset, success, free_total, peak_usage,
                    pool_bytes, input ready);
    modport sink   (input valid, granted_offset, success, free_total, peak_usage,
                    pool_bytes, output ready);
endinterface

`default_nettype wire

@@ design/first_fit_coalescing_allocator_core.sv @@
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_core
// First-fit heap allocator with an address-ordered free list and coalescing.
// ----------------------------------------------------------------------------
// Block headers (link and size) live in two 1024-entry synchronous memories,
// one per 4-byte slot. After reset a clearing pass writes the initial heap;
// no command beat is taken until it ends. Commands run one at a time. An
// allocate examines free-list entries in turn and reinserts a split
// remainder; a release walks the free list up to the insert point.
// The list walk is bound by the single read port of the header memories.
// A result beat waits in an output register, so the next command is taken
// as soon as the previous result has been registered.
`default_nettype none

module first_fit_coalescing_allocator_core
    import ffca_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    ffca_req_if.sink   i_req,
    ffca_rsp_if.source o_rsp
);

    logic [OFF_W-1:0] link_mem [DEPTH];
    logic [OFF_W-1:0] size_mem [DEPTH];

    t_state r_state, n_state;
    logic [IDX_W-1:0]  r_clr_idx, n_clr_idx;
    logic [OFF_W-1:0]  r_head, n_head;
    logic [OFF_W-1:0]  r_free, n_free;
    logic [OFF_W-1:0]  r_peak, n_peak;
    logic [NEED_W-1:0] r_need, n_need;
    logic [OFF_W:0]    r_blk, n_blk;
    logic [OFF_W-1:0]  r_prev, n_prev;
    logic              r_prev_head, n_prev_head;
    logic [OFF_W-1:0]  r_bsz, n_bsz;
    logic [OFF_W-1:0]  r_blink, n_blink;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [OFF_W:0]    r_rblk, n_rblk;
    logic [OFF_W-1:0]  r_it, n_it;
    logic              r_it_head, n_it_head;
    logic [OFF_W-1:0]  r_nx, n_nx;
    logic              r_nx_mem, n_nx_mem;
    logic              r_merged, n_merged;
    logic [OFF_W-1:0]  r_sz_it, n_sz_it;
    logic [OFF_W-1:0]  r_lk_it, n_lk_it;
    logic              r_ret_alloc, n_ret_alloc;
    logic [OFF_W-1:0]  r_granted, n_granted;
    logic              r_ok, n_ok;
    logic              r_out_valid, n_out_valid;
    logic [OFF_W-1:0]  r_out_granted, n_out_granted;
    logic              r_out_ok, n_out_ok;
    logic [OFF_W-1:0]  r_out_free, n_out_free;
    logic [OFF_W-1:0]  r_out_peak, n_out_peak;

    // memory ports
    logic              rd_en;
    logic [OFF_W:0]    rd_addr;
    logic [OFF_W-1:0]  r_rd_link, r_rd_size;
    logic              r_rd_oor;
    logic [OFF_W-1:0]  rd_link, rd_size;
    logic              lk_we, sz_we;
    logic [OFF_W:0]    lk_waddr, sz_waddr;
    logic [OFF_W-1:0]  lk_wdata, sz_wdata;

    assign rd_link = r_rd_oor ? '0 : r_rd_link;
    assign rd_size = r_rd_oor ? '0 : r_rd_size;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_link <= link_mem[rd_addr[OFF_W-1:2]];
            r_rd_size <= size_mem[rd_addr[OFF_W-1:2]];
            r_rd_oor  <= rd_addr[OFF_W];
        end
        // writes beyond the heap are dropped
        if (lk_we && !lk_waddr[OFF_W]) begin
            link_mem[lk_waddr[OFF_W-1:2]] <= lk_wdata;
        end
        if (sz_we && !sz_waddr[OFF_W]) begin
            size_mem[sz_waddr[OFF_W-1:2]] <= sz_wdata;
        end
    end

    logic              in_beat;
    logic [NEED_W-1:0] need_raw;
    logic [NEED_W-1:0] need_rnd;
    logic [OFF_W-1:0]  hdr;
    logic [OFF_W-1:0]  nx_cur;
    logic [OFF_W-1:0]  rem;
    logic [OFF_W:0]    nb;
    logic [OFF_W:0]    it_end;
    logic [OFF_W:0]    merge_sum;
    logic [OFF_W+1:0]  blk_end;
    logic [OFF_W:0]    free_sum;
    logic [OFF_W-1:0]  room;
    logic [OFF_W-1:0]  free_after;

    assign in_beat = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.granted_offset = r_out_granted;
    assign o_rsp.success        = r_out_ok;
    assign o_rsp.free_total     = r_out_free;
    assign o_rsp.peak_usage     = r_out_peak;
    assign o_rsp.pool_bytes     = TAIL_OFF;

    always_comb begin
        n_state       = r_state;
        n_clr_idx     = r_clr_idx;
        n_head        = r_head;
        n_free        = r_free;
        n_peak        = r_peak;
        n_need        = r_need;
        n_blk         = r_blk;
        n_prev        = r_prev;
        n_prev_head   = r_prev_head;
        n_bsz         = r_bsz;
        n_blink       = r_blink;
        n_cnt         = r_cnt;
        n_rblk        = r_rblk;
        n_it          = r_it;
        n_it_head     = r_it_head;
        n_nx          = r_nx;
        n_nx_mem      = r_nx_mem;
        n_merged      = r_merged;
        n_sz_it       = r_sz_it;
        n_lk_it       = r_lk_it;
        n_ret_alloc   = r_ret_alloc;
        n_granted     = r_granted;
        n_ok          = r_ok;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_granted = r_out_granted;
        n_out_ok      = r_out_ok;
        n_out_free    = r_out_free;
        n_out_peak    = r_out_peak;

        rd_en    = 1'b0;
        rd_addr  = '0;
        lk_we    = 1'b0;
        lk_waddr = '0;
        lk_wdata = '0;
        sz_we    = 1'b0;
        sz_waddr = '0;
        sz_wdata = '0;

        need_raw  = NEED_W'(i_req.request_bytes) + NEED_W'(HEADER_BYTES);
        need_rnd  = (need_raw + NEED_W'(ALIGN_STEP - 1)) & ~NEED_W'(ALIGN_STEP - 1);
        hdr       = {i_req.release_offset[OFF_W-1:2], 2'b00} - OFF_W'(HEADER_BYTES);
        nx_cur    = r_nx_mem ? rd_link : r_nx;
        rem       = r_bsz - r_need[OFF_W-1:0];
        nb        = r_blk + {1'b0, r_need[OFF_W-1:0]};
        it_end    = {1'b0, r_it} + {1'b0, r_sz_it};
        merge_sum = {1'b0, r_sz_it} + {1'b0, rd_size};
        blk_end   = {1'b0, r_rblk} + {2'b00, r_bsz};
        room      = TAIL_OFF - r_free;
        free_sum  = {1'b0, r_free} + {1'b0, rd_size};
        free_after = (rd_size > r_free) ? '0 : r_free - rd_size;

        unique case (r_state)
            S_CLEAR: begin
                lk_we    = 1'b1;
                sz_we    = 1'b1;
                lk_waddr = {1'b0, r_clr_idx, 2'b00};
                sz_waddr = {1'b0, r_clr_idx, 2'b00};
                lk_wdata = (r_clr_idx == '0) ? TAIL_OFF : '0;
                sz_wdata = (r_clr_idx == '0) ? TAIL_OFF : '0;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_beat) begin
                    n_granted = '0;
                    n_ok      = 1'b0;
                    n_state   = S_DONE;
                    if (t_op'(i_req.operation) == OP_ALLOC) begin
                        n_need = need_rnd;
                        if (i_req.request_bytes != '0 && need_rnd < NEED_W'(r_free)
                                && r_head != TAIL_OFF) begin
                            rd_en       = 1'b1;
                            rd_addr     = {1'b0, r_head};
                            n_blk       = {1'b0, r_head};
                            n_prev_head = 1'b1;
                            n_cnt       = CNT_W'(1);
                            n_state     = S_A_CHK;
                        end
                    end else if (i_req.release_offset >= OFF_W'(HEADER_BYTES)
                                 && hdr < TAIL_OFF) begin
                        rd_en   = 1'b1;
                        rd_addr = {1'b0, hdr};
                        n_rblk  = {1'b0, hdr};
                        n_state = S_R_SIZE;
                    end
                end
            end
            S_A_CHK: begin
                if (NEED_W'(rd_size) >= r_need) begin
                    n_bsz   = rd_size;
                    n_blink = rd_link;
                    n_state = S_A_TAKE;
                end else begin
                    n_prev      = r_blk[OFF_W-1:0];
                    n_prev_head = 1'b0;
                    if (rd_link == TAIL_OFF || r_cnt == WALK_MAX) begin
                        n_state = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = {1'b0, rd_link};
                        n_blk   = {1'b0, rd_link};
                        n_cnt   = r_cnt + 1'b1;
                    end
                end
            end
            S_A_TAKE: begin
                n_granted = r_blk[OFF_W-1:0] + OFF_W'(HEADER_BYTES);
                n_ok      = 1'b1;
                if (r_prev_head) begin
                    n_head = r_blink;
                end else begin
                    lk_we    = 1'b1;
                    lk_waddr = {1'b0, r_prev};
                    lk_wdata = r_blink;
                end
                if (rem >= OFF_W'(MIN_SPLIT)) begin
                    sz_we    = 1'b1;
                    sz_waddr = nb;
                    sz_wdata = rem;
                    n_state  = S_A_SPLIT;
                end else begin
                    n_state = S_A_RD;
                end
            end
            S_A_SPLIT: begin
                sz_we       = 1'b1;
                sz_waddr    = r_blk;
                sz_wdata    = r_need[OFF_W-1:0];
                n_rblk      = nb;
                n_it_head   = 1'b1;
                n_nx        = r_head;
                n_nx_mem    = 1'b0;
                n_cnt       = '0;
                n_ret_alloc = 1'b1;
                n_state     = S_RI_WALK;
            end
            S_A_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_blk;
                n_state = S_A_FIN;
            end
            S_A_FIN: begin
                n_free = free_after;
                if (free_after < TAIL_OFF - r_peak) begin
                    n_peak = TAIL_OFF - free_after;
                end
                n_state = S_DONE;
            end
            S_R_SIZE: begin
                n_free      = (rd_size > room) ? TAIL_OFF : free_sum[OFF_W-1:0];
                n_ok        = 1'b1;
                n_it_head   = 1'b1;
                n_nx        = r_head;
                n_nx_mem    = 1'b0;
                n_cnt       = '0;
                n_ret_alloc = 1'b0;
                n_state     = S_RI_WALK;
            end
            S_RI_WALK: begin
                // find the last free block below the one going back in
                if (nx_cur == TAIL_OFF || {1'b0, nx_cur} >= r_rblk || r_cnt == WALK_MAX) begin
                    n_state = S_RI_IT;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = {1'b0, nx_cur};
                    n_it      = nx_cur;
                    n_it_head = 1'b0;
                    n_nx_mem  = 1'b1;
                    n_cnt     = r_cnt + 1'b1;
                end
            end
            S_RI_IT: begin
                rd_en = 1'b1;
                if (r_it_head) begin
                    rd_addr = r_rblk;
                    n_state = S_RI_BLK;
                end else begin
                    rd_addr = {1'b0, r_it};
                    n_state = S_RI_ITD;
                end
            end
            S_RI_ITD: begin
                n_sz_it = rd_size;
                n_lk_it = rd_link;
                rd_en   = 1'b1;
                rd_addr = r_rblk;
                n_state = S_RI_BLK;
            end
            S_RI_BLK: begin
                n_nx = r_it_head ? r_head : r_lk_it;
                if (!r_it_head && it_end == r_rblk) begin
                    // merge with the lower neighbor
                    sz_we    = 1'b1;
                    sz_waddr = {1'b0, r_it};
                    sz_wdata = merge_sum[OFF_W-1:0];
                    n_rblk   = {1'b0, r_it};
                    n_bsz    = merge_sum[OFF_W-1:0];
                    n_merged = 1'b1;
                end else begin
                    n_bsz    = rd_size;
                    n_merged = 1'b0;
                end
                n_state = S_RI_NEXT;
            end
            S_RI_NEXT: begin
                if (blk_end == {2'b00, r_nx}) begin
                    if (r_nx != TAIL_OFF) begin
                        rd_en   = 1'b1;
                        rd_addr = {1'b0, r_nx};
                        n_state = S_RI_NXD;
                    end else begin
                        lk_we    = 1'b1;
                        lk_waddr = r_rblk;
                        lk_wdata = TAIL_OFF;
                        n_state  = S_RI_LINK;
                    end
                end else begin
                    lk_we    = 1'b1;
                    lk_waddr = r_rblk;
                    lk_wdata = r_nx;
                    n_state  = S_RI_LINK;
                end
            end
            S_RI_NXD: begin
                // merge with the upper neighbor
                sz_we    = 1'b1;
                sz_waddr = r_rblk;
                sz_wdata = r_bsz + rd_size;
                lk_we    = 1'b1;
                lk_waddr = r_rblk;
                lk_wdata = rd_link;
                n_state  = S_RI_LINK;
            end
            S_RI_LINK: begin
                if (r_it_head) begin
                    n_head = r_rblk[OFF_W-1:0];
                end else if (!r_merged) begin
                    lk_we    = 1'b1;
                    lk_waddr = {1'b0, r_it};
                    lk_wdata = r_rblk[OFF_W-1:0];
                end
                n_state = r_ret_alloc ? S_A_RD : S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_granted = r_granted;
                    n_out_ok      = r_ok;
                    n_out_free    = r_free;
                    n_out_peak    = r_peak;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_head      <= '0;
            r_free      <= TAIL_OFF;
            r_peak      <= PEAK_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_head      <= n_head;
            r_free      <= n_free;
            r_peak      <= n_peak;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_need        <= n_need;
        r_blk         <= n_blk;
        r_prev        <= n_prev;
        r_prev_head   <= n_prev_head;
        r_bsz         <= n_bsz;
        r_blink       <= n_blink;
        r_cnt         <= n_cnt;
        r_rblk        <= n_rblk;
        r_it          <= n_it;
        r_it_head     <= n_it_head;
        r_nx          <= n_nx;
        r_nx_mem      <= n_nx_mem;
        r_merged      <= n_merged;
        r_sz_it       <= n_sz_it;
        r_lk_it       <= n_lk_it;
        r_ret_alloc   <= n_ret_alloc;
        r_granted     <= n_granted;
        r_ok          <= n_ok;
        r_out_granted <= n_out_granted;
        r_out_ok      <= n_out_ok;
        r_out_free    <= n_out_free;
        r_out_peak    <= n_out_peak;
    end

endmodule

`default_nettype wire
